FILE: design/xmr_pkg.sv
// xmr_pkg: types and codes for the checksum xmodem receiver
// holds the phase enum, line control characters and status codes
// no dependencies
package xmr_pkg;

    // receiver phase
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HUNT = 3'd1,
        PH_NUM  = 3'd2,
        PH_COMP = 3'd3,
        PH_DATA = 3'd4,
        PH_SUM  = 3'd5
    } t_phase;

    // request command codes
    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_TIMEOUT = 2'd1;
    localparam logic [1:0] CMD_START   = 2'd2;

    // line control characters
    localparam logic [7:0] CH_SOH = 8'd1;
    localparam logic [7:0] CH_EOT = 8'd4;
    localparam logic [7:0] CH_ACK = 8'd6;
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_NAK = 8'd21;
    localparam logic [7:0] CH_CAN = 8'd24;

    // sector status codes
    localparam logic [1:0] SS_NONE    = 2'd0;
    localparam logic [1:0] SS_COMMIT  = 2'd1;
    localparam logic [1:0] SS_DISCARD = 2'd2;

    // transfer status codes
    localparam logic [2:0] TS_RUN     = 3'd0;
    localparam logic [2:0] TS_DONE    = 3'd1;
    localparam logic [2:0] TS_CANCEL  = 3'd2;
    localparam logic [2:0] TS_TIMEOUT = 3'd3;
    localparam logic [2:0] TS_ERRORS  = 3'd4;

    // burst lengths and layout of the cancel sequence
    localparam logic [3:0] LEN_NONE       = 4'd0;
    localparam logic [3:0] LEN_ONE        = 4'd1;
    localparam logic [3:0] LEN_CANCEL     = 4'd9;
    localparam logic [3:0] LEN_NAK_CANCEL = 4'd10;
    localparam logic [3:0] CAN_COUNT      = 4'd5;

    // reset value of the error limit
    localparam logic [7:0] ERROR_LIMIT_RESET = 8'd20;

endpackage

FILE: design/xmodem_checksum_receiver_core.sv
// xmodem_checksum_receiver_core: receiver side of checksum xmodem
// frame hunt, header check, payload streaming and reply burst generation
// depends on xmr_pkg
//
// Each input request (a line byte, a timeout tick or a start command in
// s_axis_tuser) updates the protocol state as it is taken; its replies go to
// a burst register that plays them out on m_axis, one per cycle while m_axis
// is ready. Most requests give at most one result, so the block sustains one
// request per cycle while the output side keeps up. A cancel sequence (five
// CAN and four backspace, optionally after a NAK) gives nine or ten results,
// and the input waits until the last of them is being taken. tlast marks the
// final result of each request. error_limit resets to 20; the user must write it
// through i_cfg_wr_en / i_cfg_wr_data while idle, which the block does not enforce.
module xmodem_checksum_receiver_core #(
    parameter int SECTOR_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: error_limit
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    // input requests
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] cmd
    // results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] tx_valid, [8:1] tx_char, [9] data_valid, [17:10] data_byte,
    // [19:18] sector_status, [22:20] transfer_status, [23] zero
    output logic [23:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast    // last
);
    import xmr_pkg::*;

    localparam int IDX_W = (SECTOR_BYTES > 1) ? $clog2(SECTOR_BYTES) : 1;
    localparam logic [IDX_W-1:0] IDX_END = IDX_W'(SECTOR_BYTES - 1);

    // protocol state
    t_phase             r_phase, n_phase;
    logic [7:0]         r_last_good, n_last_good;
    logic [7:0]         r_err_cnt, n_err_cnt;
    logic [7:0]         r_hdr_num, n_hdr_num;
    logic [IDX_W-1:0]   r_byte_idx, n_byte_idx;
    logic [7:0]         r_sum, n_sum;
    logic [7:0]         r_err_limit;

    // burst register
    logic               r_busy;
    logic [3:0]         r_idx;
    logic [3:0]         r_len, n_len;
    logic               r_nak_first, n_nak_first;
    logic               r_head_txv, n_head_txv;
    logic [7:0]         r_head_char, n_head_char;
    logic               r_head_dv, n_head_dv;
    logic [7:0]         r_head_db, n_head_db;
    logic [1:0]         r_head_ss, n_head_ss;
    logic [2:0]         r_ts, n_ts;

    logic               in_fire, out_fire, is_last;
    logic [1:0]         cmd;
    logic [7:0]         rx_byte;
    logic               partial;
    logic [7:0]         err_bump;
    logic               err_hit;
    logic [3:0]         pos;
    logic               o_txv, o_dv;
    logic [7:0]         o_char, o_db;
    logic [1:0]         o_ss;

    assign cmd      = i_s_axis_tuser;
    assign rx_byte  = i_s_axis_tdata;
    assign is_last  = (r_idx == r_len - 4'd1);
    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;

    // take a new request when the burst register is empty or draining its last result
    assign o_s_axis_tready = !r_busy || (i_m_axis_tready && is_last);

    // payload of an unfinished sector already given out
    assign partial  = ((r_phase == PH_DATA) && (r_byte_idx != '0)) || (r_phase == PH_SUM);
    // saturating error count and limit check
    assign err_bump = (r_err_cnt == 8'hff) ? r_err_cnt : r_err_cnt + 8'd1;
    assign err_hit  = (err_bump >= r_err_limit);

    // next protocol state and reply burst for the request
    always_comb begin
        n_phase     = r_phase;
        n_last_good = r_last_good;
        n_err_cnt   = r_err_cnt;
        n_hdr_num   = r_hdr_num;
        n_byte_idx  = r_byte_idx;
        n_sum       = r_sum;
        n_len       = LEN_NONE;
        n_nak_first = 1'b0;
        n_head_txv  = 1'b1;
        n_head_char = CH_NAK;
        n_head_dv   = 1'b0;
        n_head_db   = 8'd0;
        n_head_ss   = SS_NONE;
        n_ts        = TS_RUN;
        case (cmd)
            CMD_START: begin
                n_last_good = 8'd0;
                n_err_cnt   = 8'd0;
                n_phase     = PH_HUNT;
                n_len       = LEN_ONE;
                n_head_ss   = partial ? SS_DISCARD : SS_NONE;
            end
            CMD_TIMEOUT: begin
                if (r_phase != PH_IDLE) begin
                    n_err_cnt = err_bump;
                    n_head_ss = partial ? SS_DISCARD : SS_NONE;
                    if (!err_hit) begin
                        n_len   = LEN_ONE;
                        n_phase = PH_HUNT;
                    end else begin
                        n_len       = LEN_CANCEL;
                        n_head_char = CH_CAN;
                        n_ts        = TS_TIMEOUT;
                        n_phase     = PH_IDLE;
                    end
                end
            end
            CMD_BYTE: begin
                case (r_phase)
                    PH_HUNT: begin
                        if (rx_byte == CH_SOH) begin
                            n_phase = PH_NUM;
                        end else if (rx_byte == CH_EOT) begin
                            n_len       = LEN_ONE;
                            n_head_char = CH_ACK;
                            n_ts        = TS_DONE;
                            n_phase     = PH_IDLE;
                        end else if (rx_byte == CH_CAN) begin
                            n_len       = LEN_CANCEL;
                            n_head_char = CH_CAN;
                            n_ts        = TS_CANCEL;
                            n_phase     = PH_IDLE;
                        end
                    end
                    PH_NUM: begin
                        n_hdr_num = rx_byte;
                        n_phase   = PH_COMP;
                    end
                    PH_COMP: begin
                        if (({1'b0, r_hdr_num} + {1'b0, rx_byte}) == 9'd255
                            && r_hdr_num == r_last_good + 8'd1) begin
                            n_byte_idx = '0;
                            n_sum      = 8'd0;
                            n_phase    = PH_DATA;
                        end else if (({1'b0, r_hdr_num} + {1'b0, rx_byte}) == 9'd255
                            && r_hdr_num == r_last_good) begin
                            n_len       = LEN_ONE;
                            n_head_char = CH_ACK;
                            n_phase     = PH_HUNT;
                        end else begin
                            // bad complement or unexpected sector
                            n_err_cnt = err_bump;
                            if (err_hit) begin
                                n_len       = LEN_NAK_CANCEL;
                                n_nak_first = 1'b1;
                                n_ts        = TS_ERRORS;
                                n_phase     = PH_IDLE;
                            end else begin
                                n_len   = LEN_ONE;
                                n_phase = PH_HUNT;
                            end
                        end
                    end
                    PH_DATA: begin
                        n_sum       = r_sum + rx_byte;
                        n_len       = LEN_ONE;
                        n_head_txv  = 1'b0;
                        n_head_char = 8'd0;
                        n_head_dv   = 1'b1;
                        n_head_db   = rx_byte;
                        if (r_byte_idx == IDX_END) begin
                            n_byte_idx = '0;
                            n_phase    = PH_SUM;
                        end else begin
                            n_byte_idx = r_byte_idx + IDX_W'(1);
                        end
                    end
                    PH_SUM: begin
                        if (rx_byte == r_sum) begin
                            n_last_good = r_last_good + 8'd1;
                            n_err_cnt   = 8'd0;
                            n_len       = LEN_ONE;
                            n_head_char = CH_ACK;
                            n_head_ss   = SS_COMMIT;
                            n_phase     = PH_HUNT;
                        end else begin
                            // checksum mismatch
                            n_err_cnt = err_bump;
                            n_head_ss = SS_DISCARD;
                            if (err_hit) begin
                                n_len       = LEN_NAK_CANCEL;
                                n_nak_first = 1'b1;
                                n_ts        = TS_ERRORS;
                                n_phase     = PH_IDLE;
                            end else begin
                                n_len   = LEN_ONE;
                                n_phase = PH_HUNT;
                            end
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            default: begin
                n_len = LEN_NONE;
            end
        endcase
    end

    // protocol state registers and error limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_last_good <= 8'd0;
            r_err_cnt   <= 8'd0;
            r_hdr_num   <= 8'd0;
            r_byte_idx  <= '0;
            r_sum       <= 8'd0;
            r_err_limit <= ERROR_LIMIT_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_err_limit <= i_cfg_wr_data;
            end
            if (in_fire) begin
                r_phase     <= n_phase;
                r_last_good <= n_last_good;
                r_err_cnt   <= n_err_cnt;
                r_hdr_num   <= n_hdr_num;
                r_byte_idx  <= n_byte_idx;
                r_sum       <= n_sum;
            end
        end
    end

    // burst control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 4'd0;
        end else begin
            if (in_fire && n_len != LEN_NONE) begin
                r_busy <= 1'b1;
                r_idx  <= 4'd0;
            end else if (out_fire) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    // burst payload
    always_ff @(posedge i_clk) begin
        if (in_fire && n_len != LEN_NONE) begin
            r_len       <= n_len;
            r_nak_first <= n_nak_first;
            r_head_txv  <= n_head_txv;
            r_head_char <= n_head_char;
            r_head_dv   <= n_head_dv;
            r_head_db   <= n_head_db;
            r_head_ss   <= n_head_ss;
            r_ts        <= n_ts;
        end
    end

    // result selection within the burst
    assign pos = r_idx - {3'b000, r_nak_first};
    always_comb begin
        if (r_idx == 4'd0) begin
            o_txv  = r_head_txv;
            o_char = r_head_char;
            o_dv   = r_head_dv;
            o_db   = r_head_db;
            o_ss   = r_head_ss;
        end else begin
            o_txv  = 1'b1;
            o_char = (pos < CAN_COUNT) ? CH_CAN : CH_BS;
            o_dv   = 1'b0;
            o_db   = 8'd0;
            o_ss   = SS_NONE;
        end
    end

    assign o_m_axis_tvalid = r_busy;
    assign o_m_axis_tlast  = is_last;
    assign o_m_axis_tdata  = {1'b0, r_ts, o_ss, o_db, o_dv, o_char, o_txv};

    // burst position stays inside its length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_len))
        else $error("burst index past burst length");

    // a request taken while busy only when the last result leaves
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_busy) |-> (out_fire && is_last))
        else $error("request taken over a pending burst");

    // results before the last one are always reply characters
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !is_last) |-> (o_txv && !o_dv))
        else $error("non-final result is not a reply character");

    // a multi-result burst always ends the transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && n_len > LEN_ONE) |=> (r_phase == PH_IDLE))
        else $error("cancel burst left the receiver running");

endmodule
